// ===== rtl/latm_to_adts_repacker_top_macros.svh =====
// Assertion macros for the repacker checker
`ifndef LATM_TO_ADTS_REPACKER_TOP_MACROS_SVH
`define LATM_TO_ADTS_REPACKER_TOP_MACROS_SVH

// clocked check with reset disable
`define L2A_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form
`define L2A_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/latm2adts_pkg.sv =====
package latm2adts_pkg;

  typedef enum logic [4:0] {
    PH_USE_SAME, PH_VERSION, PH_VERSION_A, PH_SKIP7, PH_NPROG, PH_NLAYER,
    PH_AOT, PH_AOT_EXT, PH_SRI, PH_RATE24, PH_CHAN, PH_PEEK, PH_ESRI,
    PH_ERATE24, PH_AOT2, PH_AOT2_EXT, PH_FRAMELEN, PH_DEPENDS, PH_SKIPDELAY,
    PH_EXTFLAG, PH_SKIPEXT3, PH_FLT, PH_SKIPFLT, PH_OTHER, PH_OTHERCHUNK,
    PH_CRC, PH_SKIPCRC, PH_LEN, PH_PAY, PH_DONE, PH_DROP
  } ph_t;

  typedef enum logic [3:0] {
    CS_IDLE = 4'b0001,
    CS_BIT  = 4'b0010,
    CS_HDR  = 4'b0100,
    CS_END  = 4'b1000
  } ctrl_st_t;

  typedef struct packed {
    logic       load;
    logic       bit_step;
    logic       hdr_emit;
    logic [2:0] hdr_idx;
    logic       end_step;
  } cmd_t;

  typedef struct packed {
    logic src_empty;
    logic out_free;
    logic hdr_start;
  } status_t;

  localparam logic [2:0]  HDR_LAST_IDX = 3'd6;
  localparam logic [15:0] MAX_SLOT     = 16'd8184;
  localparam logic [23:0] RATE_MIN     = 24'd7350;
  localparam logic [23:0] RATE_MAX     = 24'd96000;
  localparam logic [23:0] RATE_SBR_MAX = 24'd24000;
  localparam logic [7:0]  LEN_ESCAPE   = 8'd255;
  localparam logic [10:0] FULLNESS     = 11'h7ff;

  function automatic logic [16:0] rate_of(input logic [3:0] idx);
    logic [16:0] r;
    case (idx)
      4'd0:    r = 17'd96000;
      4'd1:    r = 17'd88200;
      4'd2:    r = 17'd64000;
      4'd3:    r = 17'd48000;
      4'd4:    r = 17'd44100;
      4'd5:    r = 17'd32000;
      4'd6:    r = 17'd24000;
      4'd7:    r = 17'd22050;
      4'd8:    r = 17'd16000;
      4'd9:    r = 17'd12000;
      4'd10:   r = 17'd11025;
      4'd11:   r = 17'd8000;
      4'd12:   r = 17'd7350;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  function automatic logic rate_ok(input logic [23:0] r);
    return (r >= RATE_MIN) && (r <= RATE_MAX);
  endfunction

  // index+1 of the doubled core rate in the table, 0 when absent
  function automatic logic [4:0] double_idx(input logic [23:0] core);
    logic [24:0] dbl;
    logic [4:0]  f;
    dbl = {core, 1'b0};
    f = 5'd0;
    for (int i = 12; i >= 0; i--) begin
      if (dbl == {8'd0, rate_of(4'(i))}) begin
        f = 5'(i + 1);
      end
    end
    return f;
  endfunction

  function automatic logic [5:0] escaped_type(input logic [5:0] v);
    return v[5] ? 6'd63 : {1'b1, v[4:0]};
  endfunction

endpackage

// ===== rtl/latm2adts_if.sv =====
interface latm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       element_end;
  modport source (output valid, output data_byte, output element_end, input ready);
  modport sink (input valid, input data_byte, input element_end, output ready);
endinterface

interface latm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       frame_bad;
  logic [3:0] rate_index_out;
  logic [4:0] ext_rate_index_out;
  logic [3:0] channel_count;
  modport source (output valid, output out_byte, output out_last, output frame_bad,
                  output rate_index_out, output ext_rate_index_out,
                  output channel_count, input ready);
  modport sink (input valid, input out_byte, input out_last, input frame_bad,
                input rate_index_out, input ext_rate_index_out,
                input channel_count, output ready);
endinterface

// ===== rtl/latm2adts_ctrl.sv =====
module latm2adts_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  latm2adts_pkg::status_t st,
  output latm2adts_pkg::cmd_t    cmd
);

  latm2adts_pkg::ctrl_st_t state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.hdr_idx = idx_r;
    in_ready = 1'b0;
    case (state_r)
      latm2adts_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = latm2adts_pkg::CS_BIT;
        end
      end
      latm2adts_pkg::CS_BIT: begin
        if (st.src_empty) begin
          state_nxt = latm2adts_pkg::CS_END;
        end else if (st.out_free) begin
          cmd.bit_step = 1'b1;
          if (st.hdr_start) begin
            idx_nxt = 3'd0;
            state_nxt = latm2adts_pkg::CS_HDR;
          end
        end
      end
      latm2adts_pkg::CS_HDR: begin
        if (st.out_free) begin
          cmd.hdr_emit = 1'b1;
          if (idx_r == latm2adts_pkg::HDR_LAST_IDX) begin
            state_nxt = latm2adts_pkg::CS_BIT;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      latm2adts_pkg::CS_END: begin
        if (st.out_free) begin
          cmd.end_step = 1'b1;
          state_nxt = latm2adts_pkg::CS_IDLE;
        end
      end
      default: state_nxt = latm2adts_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= latm2adts_pkg::CS_IDLE;
      idx_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== rtl/latm2adts_dp.sv =====
module latm2adts_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             data_byte,
  input  logic                   element_end,
  input  latm2adts_pkg::cmd_t    cmd,
  output latm2adts_pkg::status_t st,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  output logic                   frame_bad,
  output logic [3:0]             rate_index_out,
  output logic [4:0]             ext_rate_index_out,
  output logic [3:0]             channel_count
);

  logic [7:0]  byte_sr_r, byte_sr_nxt;
  logic [3:0]  bits_left_r, bits_left_nxt;
  logic        end_r, end_nxt;
  logic [8:0]  rpl_sr_r, rpl_sr_nxt;
  logic [3:0]  rpl_left_r, rpl_left_nxt;
  latm2adts_pkg::ph_t ph_r, ph_nxt;
  logic [4:0]  fc_r, fc_nxt;
  logic [23:0] win_r, win_nxt;
  logic        cv_r, cv_nxt;
  logic [5:0]  ot_r, ot_nxt;
  logic [2:0]  lt_r, lt_nxt;
  logic [3:0]  ri_r, ri_nxt;
  logic [4:0]  eri_r, eri_nxt;
  logic [3:0]  cs_r, cs_nxt;
  logic [23:0] core_r, core_nxt;
  logic [15:0] pl_r, pl_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic        ov_r, ov_nxt;
  logic [7:0]  ob_r, ob_nxt;
  logic        ol_r, ol_nxt;
  logic        obad_r, obad_nxt;
  logic [3:0]  ori_r, ori_nxt;
  logic [4:0]  oeri_r, oeri_nxt;
  logic [3:0]  occ_r, occ_nxt;

  logic        b;
  logic [23:0] v;
  logic [16:0] len_sum;
  logic [15:0] len_sat;
  logic [4:0]  dbl_f;
  logic        emit;
  logic [7:0]  e_byte;
  logic        e_last;
  logic        e_bad;
  logic        hdr_go;
  logic [12:0] adts_len;
  logic [1:0]  prof;
  logic        ph_active;

  assign b = (rpl_left_r != 4'd0) ? rpl_sr_r[8] : byte_sr_r[7];
  assign v = {win_r[22:0], b};
  assign len_sum = {1'b0, pl_r} + {9'd0, v[7:0]};
  assign len_sat = len_sum[16] ? 16'hffff : len_sum[15:0];
  assign dbl_f = latm2adts_pkg::double_idx(core_r);
  assign adts_len = pl_r[12:0] + 13'd7;
  assign prof = (ot_r == 6'd1) ? 2'd0 : (ot_r == 6'd2) ? 2'd1 :
                (ot_r == 6'd3) ? 2'd2 : 2'd3;
  assign ph_active = (ph_r != latm2adts_pkg::PH_DONE) && (ph_r != latm2adts_pkg::PH_DROP);

  assign hdr_go = ph_active && (ph_r == latm2adts_pkg::PH_LEN) && (fc_r <= 5'd1) &&
                  (v[7:0] != latm2adts_pkg::LEN_ESCAPE) && (len_sat <= latm2adts_pkg::MAX_SLOT);

  assign st.src_empty = (bits_left_r == 4'd0) && (rpl_left_r == 4'd0);
  assign st.out_free = !ov_r || out_ready;
  assign st.hdr_start = hdr_go;

  always_comb begin
    byte_sr_nxt = byte_sr_r;
    bits_left_nxt = bits_left_r;
    end_nxt = end_r;
    rpl_sr_nxt = rpl_sr_r;
    rpl_left_nxt = rpl_left_r;
    ph_nxt = ph_r;
    fc_nxt = fc_r;
    win_nxt = win_r;
    cv_nxt = cv_r;
    ot_nxt = ot_r;
    lt_nxt = lt_r;
    ri_nxt = ri_r;
    eri_nxt = eri_r;
    cs_nxt = cs_r;
    core_nxt = core_r;
    pl_nxt = pl_r;
    rem_nxt = rem_r;
    emit = 1'b0;
    e_byte = 8'd0;
    e_last = 1'b0;
    e_bad = 1'b0;

    if (cmd.load) begin
      byte_sr_nxt = data_byte;
      bits_left_nxt = 4'd8;
      end_nxt = element_end;
    end else if (cmd.bit_step) begin
      if (rpl_left_r != 4'd0) begin
        rpl_sr_nxt = {rpl_sr_r[7:0], 1'b0};
        rpl_left_nxt = rpl_left_r - 4'd1;
      end else begin
        byte_sr_nxt = {byte_sr_r[6:0], 1'b0};
        bits_left_nxt = bits_left_r - 4'd1;
      end
      if (ph_active) begin
        if (fc_r > 5'd1) begin
          fc_nxt = fc_r - 5'd1;
          win_nxt = v;
        end else begin
          win_nxt = '0;
          fc_nxt = 5'd1;
          case (ph_r)
            latm2adts_pkg::PH_USE_SAME: begin
              if (v[0]) begin
                if (!cv_r || (lt_r != 3'd0)) begin
                  ph_nxt = latm2adts_pkg::PH_DROP;
                end else begin
                  ph_nxt = latm2adts_pkg::PH_LEN;
                  fc_nxt = 5'd8;
                end
              end else begin
                ph_nxt = latm2adts_pkg::PH_VERSION;
              end
            end
            latm2adts_pkg::PH_VERSION: begin
              if (v[0]) begin
                ph_nxt = latm2adts_pkg::PH_VERSION_A;
              end else begin
                ph_nxt = latm2adts_pkg::PH_SKIP7;
                fc_nxt = 5'd7;
              end
            end
            latm2adts_pkg::PH_VERSION_A: begin
              ph_nxt = latm2adts_pkg::PH_DROP;
              if (!v[0]) cv_nxt = 1'b0;
            end
            latm2adts_pkg::PH_SKIP7: begin
              ph_nxt = latm2adts_pkg::PH_NPROG;
              fc_nxt = 5'd4;
            end
            latm2adts_pkg::PH_NPROG: begin
              if (v[3:0] != 4'd0) begin
                cv_nxt = 1'b0;
                ph_nxt = latm2adts_pkg::PH_DROP;
              end else begin
                ph_nxt = latm2adts_pkg::PH_NLAYER;
                fc_nxt = 5'd3;
              end
            end
            latm2adts_pkg::PH_NLAYER: begin
              if (v[2:0] != 3'd0) begin
                cv_nxt = 1'b0;
                ph_nxt = latm2adts_pkg::PH_DROP;
              end else begin
                ph_nxt = latm2adts_pkg::PH_AOT;
                fc_nxt = 5'd5;
              end
            end
            latm2adts_pkg::PH_AOT, latm2adts_pkg::PH_AOT2: begin
              if (v[4:0] == 5'd31) begin
                ph_nxt = (ph_r == latm2adts_pkg::PH_AOT) ? latm2adts_pkg::PH_AOT_EXT :
                         latm2adts_pkg::PH_AOT2_EXT;
                fc_nxt = 5'd6;
              end else begin
                ot_nxt = {1'b0, v[4:0]};
                if (ph_r == latm2adts_pkg::PH_AOT) begin
                  ph_nxt = latm2adts_pkg::PH_SRI;
                  fc_nxt = 5'd4;
                end else begin
                  ph_nxt = latm2adts_pkg::PH_FRAMELEN;
                end
              end
            end
            latm2adts_pkg::PH_AOT_EXT: begin
              ot_nxt = latm2adts_pkg::escaped_type(v[5:0]);
              ph_nxt = latm2adts_pkg::PH_SRI;
              fc_nxt = 5'd4;
            end
            latm2adts_pkg::PH_AOT2_EXT: begin
              ot_nxt = latm2adts_pkg::escaped_type(v[5:0]);
              ph_nxt = latm2adts_pkg::PH_FRAMELEN;
            end
            latm2adts_pkg::PH_SRI: begin
              ri_nxt = v[3:0];
              if (v[3:0] == 4'd15) begin
                ph_nxt = latm2adts_pkg::PH_RATE24;
                fc_nxt = 5'd24;
              end else begin
                core_nxt = {7'd0, latm2adts_pkg::rate_of(v[3:0])};
                ph_nxt = latm2adts_pkg::PH_CHAN;
                fc_nxt = 5'd4;
              end
            end
            latm2adts_pkg::PH_RATE24: begin
              core_nxt = v;
              ph_nxt = latm2adts_pkg::PH_CHAN;
              fc_nxt = 5'd4;
            end
            latm2adts_pkg::PH_CHAN, latm2adts_pkg::PH_PEEK: begin
              if (ph_r == latm2adts_pkg::PH_CHAN) begin
                cs_nxt = v[3:0];
                eri_nxt = 5'd0;
              end
              if ((ph_r == latm2adts_pkg::PH_CHAN) &&
                  (!latm2adts_pkg::rate_ok(core_r) || (v[3:0] == 4'd0) || v[3])) begin
                // a rejected channel setup keeps the extension index
                eri_nxt = eri_r;
                cv_nxt = 1'b0;
                ph_nxt = latm2adts_pkg::PH_DROP;
              end else if ((ph_r == latm2adts_pkg::PH_CHAN) && (ot_r == 6'd5)) begin
                ph_nxt = latm2adts_pkg::PH_ESRI;
                fc_nxt = 5'd4;
              end else if ((ph_r == latm2adts_pkg::PH_CHAN) && (ot_r == 6'd26)) begin
                ph_nxt = latm2adts_pkg::PH_PEEK;
                fc_nxt = 5'd9;
              end else if ((ph_r == latm2adts_pkg::PH_PEEK) &&
                           !((v[7:6] != 2'd0) && (v[5:0] == 6'd0))) begin
                ph_nxt = latm2adts_pkg::PH_ESRI;
                fc_nxt = 5'd4;
              end else if ((core_r <= latm2adts_pkg::RATE_SBR_MAX) && (dbl_f == 5'd0)) begin
                cv_nxt = 1'b0;
                ph_nxt = latm2adts_pkg::PH_DROP;
              end else begin
                if (core_r <= latm2adts_pkg::RATE_SBR_MAX) eri_nxt = dbl_f;
                ph_nxt = latm2adts_pkg::PH_FRAMELEN;
              end
              if (ph_r == latm2adts_pkg::PH_PEEK) begin
                rpl_sr_nxt = v[8:0];
                rpl_left_nxt = 4'd9;
              end
            end
            latm2adts_pkg::PH_ESRI: begin
              eri_nxt = {1'b0, v[3:0]} + 5'd1;
              if (v[3:0] == 4'd15) begin
                ph_nxt = latm2adts_pkg::PH_ERATE24;
                fc_nxt = 5'd24;
              end else if (!latm2adts_pkg::rate_ok({7'd0, latm2adts_pkg::rate_of(v[3:0])})) begin
                cv_nxt = 1'b0;
                ph_nxt = latm2adts_pkg::PH_DROP;
              end else begin
                ph_nxt = latm2adts_pkg::PH_AOT2;
                fc_nxt = 5'd5;
              end
            end
            latm2adts_pkg::PH_ERATE24: begin
              if (!latm2adts_pkg::rate_ok(v)) begin
                cv_nxt = 1'b0;
                ph_nxt = latm2adts_pkg::PH_DROP;
              end else begin
                ph_nxt = latm2adts_pkg::PH_AOT2;
                fc_nxt = 5'd5;
              end
            end
            latm2adts_pkg::PH_FRAMELEN: begin
              if (v[0]) begin
                cv_nxt = 1'b0;
                ph_nxt = latm2adts_pkg::PH_DROP;
              end else begin
                ph_nxt = latm2adts_pkg::PH_DEPENDS;
              end
            end
            latm2adts_pkg::PH_DEPENDS: begin
              if (v[0]) begin
                ph_nxt = latm2adts_pkg::PH_SKIPDELAY;
                fc_nxt = 5'd14;
              end else begin
                ph_nxt = latm2adts_pkg::PH_EXTFLAG;
              end
            end
            latm2adts_pkg::PH_SKIPDELAY: ph_nxt = latm2adts_pkg::PH_EXTFLAG;
            latm2adts_pkg::PH_EXTFLAG: begin
              if (v[0]) begin
                ph_nxt = latm2adts_pkg::PH_SKIPEXT3;
              end else begin
                ph_nxt = latm2adts_pkg::PH_FLT;
                fc_nxt = 5'd3;
              end
            end
            latm2adts_pkg::PH_SKIPEXT3: begin
              ph_nxt = latm2adts_pkg::PH_FLT;
              fc_nxt = 5'd3;
            end
            latm2adts_pkg::PH_FLT: begin
              lt_nxt = v[2:0];
              ph_nxt = latm2adts_pkg::PH_SKIPFLT;
              case (v[2:0])
                3'd0:    fc_nxt = 5'd8;
                3'd1:    fc_nxt = 5'd9;
                3'd2:    ph_nxt = latm2adts_pkg::PH_OTHER;
                3'd3, 3'd4, 3'd5: fc_nxt = 5'd6;
                default: fc_nxt = 5'd1;
              endcase
            end
            latm2adts_pkg::PH_SKIPFLT: ph_nxt = latm2adts_pkg::PH_OTHER;
            latm2adts_pkg::PH_OTHER, latm2adts_pkg::PH_OTHERCHUNK: begin
              if ((ph_r == latm2adts_pkg::PH_OTHER) ? v[0] : v[8]) begin
                ph_nxt = latm2adts_pkg::PH_OTHERCHUNK;
                fc_nxt = 5'd9;
              end else begin
                ph_nxt = latm2adts_pkg::PH_CRC;
              end
            end
            latm2adts_pkg::PH_CRC, latm2adts_pkg::PH_SKIPCRC: begin
              if ((ph_r == latm2adts_pkg::PH_CRC) && v[0]) begin
                ph_nxt = latm2adts_pkg::PH_SKIPCRC;
                fc_nxt = 5'd8;
              end else begin
                cv_nxt = 1'b1;
                if (lt_r != 3'd0) begin
                  ph_nxt = latm2adts_pkg::PH_DROP;
                end else begin
                  ph_nxt = latm2adts_pkg::PH_LEN;
                  fc_nxt = 5'd8;
                end
              end
            end
            latm2adts_pkg::PH_LEN: begin
              pl_nxt = len_sat;
              if (v[7:0] == latm2adts_pkg::LEN_ESCAPE) begin
                ph_nxt = latm2adts_pkg::PH_LEN;
                fc_nxt = 5'd8;
              end else if (len_sat > latm2adts_pkg::MAX_SLOT) begin
                emit = 1'b1;
                e_last = 1'b1;
                e_bad = 1'b1;
                ph_nxt = latm2adts_pkg::PH_DROP;
              end else begin
                rem_nxt = len_sat[12:0];
                if (len_sat == 16'd0) begin
                  ph_nxt = latm2adts_pkg::PH_DONE;
                end else begin
                  ph_nxt = latm2adts_pkg::PH_PAY;
                  fc_nxt = 5'd8;
                end
              end
            end
            latm2adts_pkg::PH_PAY: begin
              rem_nxt = rem_r - 13'd1;
              emit = 1'b1;
              e_byte = v[7:0];
              e_last = (rem_nxt == 13'd0);
              if (rem_nxt == 13'd0) begin
                ph_nxt = latm2adts_pkg::PH_DONE;
              end else begin
                ph_nxt = latm2adts_pkg::PH_PAY;
                fc_nxt = 5'd8;
              end
            end
            default: ph_nxt = latm2adts_pkg::PH_DROP;
          endcase
        end
      end
    end else if (cmd.hdr_emit) begin
      emit = 1'b1;
      case (cmd.hdr_idx)
        3'd0: e_byte = 8'hff;
        3'd1: e_byte = 8'hf1;
        3'd2: e_byte = {prof, ri_r, 1'b1, cs_r[2]};
        3'd3: e_byte = {cs_r[1:0], 4'hf, adts_len[12:11]};
        3'd4: e_byte = adts_len[10:3];
        3'd5: e_byte = {adts_len[2:0], latm2adts_pkg::FULLNESS[10:6]};
        3'd6: begin
          e_byte = {latm2adts_pkg::FULLNESS[5:0], 2'b00};
          e_last = (pl_r == 16'd0);
        end
        default: e_byte = 8'd0;
      endcase
    end else if (cmd.end_step) begin
      if (end_r) begin
        if (ph_r == latm2adts_pkg::PH_PAY) begin
          emit = 1'b1;
          e_last = 1'b1;
          e_bad = 1'b1;
        end else if ((ph_r >= latm2adts_pkg::PH_VERSION) &&
                     (ph_r <= latm2adts_pkg::PH_SKIPCRC)) begin
          cv_nxt = 1'b0;
        end
        pl_nxt = 16'd0;
        rem_nxt = 13'd0;
        ph_nxt = latm2adts_pkg::PH_USE_SAME;
        fc_nxt = 5'd1;
        win_nxt = '0;
      end
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    obad_nxt = obad_r;
    ori_nxt = ori_r;
    oeri_nxt = oeri_r;
    occ_nxt = occ_r;
    if (emit) begin
      ov_nxt = 1'b1;
      ob_nxt = e_byte;
      ol_nxt = e_last;
      obad_nxt = e_bad;
      ori_nxt = ri_r;
      oeri_nxt = eri_r;
      occ_nxt = (cs_r == 4'd7) ? 4'd8 : cs_r;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_left_r <= 4'd0;
      rpl_left_r <= 4'd0;
      end_r <= 1'b0;
      ph_r <= latm2adts_pkg::PH_USE_SAME;
      fc_r <= 5'd1;
      win_r <= '0;
      cv_r <= 1'b0;
      ot_r <= 6'd0;
      lt_r <= 3'd0;
      ri_r <= 4'd0;
      eri_r <= 5'd0;
      cs_r <= 4'd0;
      core_r <= 24'd0;
      pl_r <= 16'd0;
      rem_r <= 13'd0;
      ov_r <= 1'b0;
    end else begin
      bits_left_r <= bits_left_nxt;
      rpl_left_r <= rpl_left_nxt;
      end_r <= end_nxt;
      ph_r <= ph_nxt;
      fc_r <= fc_nxt;
      win_r <= win_nxt;
      cv_r <= cv_nxt;
      ot_r <= ot_nxt;
      lt_r <= lt_nxt;
      ri_r <= ri_nxt;
      eri_r <= eri_nxt;
      cs_r <= cs_nxt;
      core_r <= core_nxt;
      pl_r <= pl_nxt;
      rem_r <= rem_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_sr_r <= byte_sr_nxt;
    rpl_sr_r <= rpl_sr_nxt;
    ob_r <= ob_nxt;
    ol_r <= ol_nxt;
    obad_r <= obad_nxt;
    ori_r <= ori_nxt;
    oeri_r <= oeri_nxt;
    occ_r <= occ_nxt;
  end

  assign out_valid = ov_r;
  assign out_byte = ob_r;
  assign out_last = ol_r;
  assign frame_bad = obad_r;
  assign rate_index_out = ori_r;
  assign ext_rate_index_out = oeri_r;
  assign channel_count = occ_r;

endmodule

// ===== rtl/latm_to_adts_repacker_top.sv =====
// Operation: a request is taken only in the idle state, then the element bits are stepped
// through one per cycle while the output register is free; a new byte is taken only after
// the current one is done: accept, bit steps, an empty check, an end step.
// The 9-bit lookahead in the config is replayed bit by bit; each emitted byte needs a free
// output register, so the seven header bytes and output stalls hold back the bit steps.
// Reset (rst_n low, synchronous): config invalid, parser at start of element, no output.
module latm_to_adts_repacker_top (
  input  logic        clk,
  input  logic        rst_n,
  latm_in_if.sink     in_ch,
  latm_out_if.source  out_ch
);

  latm2adts_pkg::cmd_t    cmd;
  latm2adts_pkg::status_t st;
  logic                   in_ready;

  latm2adts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  latm2adts_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .data_byte          (in_ch.data_byte),
    .element_end        (in_ch.element_end),
    .cmd                (cmd),
    .st                 (st),
    .out_valid          (out_ch.valid),
    .out_ready          (out_ch.ready),
    .out_byte           (out_ch.out_byte),
    .out_last           (out_ch.out_last),
    .frame_bad          (out_ch.frame_bad),
    .rate_index_out     (out_ch.rate_index_out),
    .ext_rate_index_out (out_ch.ext_rate_index_out),
    .channel_count      (out_ch.channel_count)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== rtl/latm2adts_chk.sv =====
`include "latm_to_adts_repacker_top_macros.svh"

module latm2adts_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       frame_bad,
  input logic [4:0] ext_rate_index_out,
  input logic [3:0] channel_count
);

  `L2A_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)), "stalled result changed")
  `L2A_ASSERT_IMPL(a_bad_last, clk, rst_n, out_valid && frame_bad, out_last && (out_byte == 8'd0), "bad item not a zero last byte")
  `L2A_ASSERT_IMPL(a_chan, clk, rst_n, out_valid, (channel_count != 4'd0) && (channel_count <= 4'd8), "channel count out of range")
  `L2A_ASSERT_IMPL(a_eri, clk, rst_n, out_valid, ext_rate_index_out <= 5'd16, "extension index out of range")

endmodule

bind latm_to_adts_repacker_top latm2adts_chk u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_byte           (out_ch.out_byte),
  .out_last           (out_ch.out_last),
  .frame_bad          (out_ch.frame_bad),
  .ext_rate_index_out (out_ch.ext_rate_index_out),
  .channel_count      (out_ch.channel_count)
);

// ===== dv/tb.sv =====
module tb;
  import latm2adts_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       bad;
    logic [3:0] ri;
    logic [4:0] eri;
    logic [3:0] cc;
  } adts_item_t;

  class adts_scoreboard;
    bit          cfg_ok, ver_a;
    int unsigned obj, len_type, ri, eri, chan_cfg;
    ph_t         ph;
    int unsigned fcnt, win, core_rate, plen, prem;
    int          nemit, errors, results;
    adts_item_t  frame_q[$];
    int unsigned rate_tab[16] = '{96000, 88200, 64000, 48000, 44100, 32000, 24000,
                                  22050, 16000, 12000, 11025, 8000, 7350, 0, 0, 0};

    function new();
      cfg_ok = 0; ver_a = 0; obj = 0; len_type = 0; ri = 0; eri = 0; chan_cfg = 0;
      core_rate = 0; errors = 0; results = 0;
      start_element();
    endfunction

    function void go(ph_t p, int unsigned n);
      ph = p; fcnt = n; win = 0;
    endfunction

    function void start_element();
      plen = 0; prem = 0;
      go(PH_USE_SAME, 1);
    endfunction

    function void fail();
      cfg_ok = 0;
      go(PH_DROP, 1);
    endfunction

    function bit in_range(int unsigned r);
      return r >= 7350 && r <= 96000;
    endfunction

    function int unsigned esc_type(int unsigned v);
      int unsigned t;
      t = 32 + (v & 'h3f);
      return t > 63 ? 63 : t;
    endfunction

    function void emit(int unsigned b, bit l, bit bad);
      adts_item_t it;
      if (nemit >= 8) return;
      it.data = b[7:0]; it.last = l; it.bad = bad;
      it.ri = ri[3:0]; it.eri = eri[4:0];
      it.cc = (chan_cfg == 7) ? 4'd8 : chan_cfg[3:0];
      frame_q.push_back(it);
      nemit++;
    endfunction

    function void after_core();
      int unsigned found;
      found = 16;
      if (core_rate <= 24000) begin
        for (int i = 0; i < 13; i++)
          if (found == 16 && rate_tab[i] == core_rate * 2) found = i;
        if (found == 16) begin
          fail();
          return;
        end
        eri = found + 1;
      end
      go(PH_FRAMELEN, 1);
    endfunction

    function void commit();
      cfg_ok = 1;
      if (len_type != 0) go(PH_DROP, 1);
      else go(PH_LEN, 8);
    endfunction

    function void emit_header();
      int unsigned len, prof;
      len = (plen + 7) & 'h1fff;
      prof = obj == 1 ? 0 : obj == 2 ? 1 : obj == 3 ? 2 : 3;
      emit('hff, 0, 0);
      emit('hf1, 0, 0);
      emit((prof << 6) | (ri << 2) | 2 | ((chan_cfg >> 2) & 1), 0, 0);
      emit(((chan_cfg & 3) << 6) | 'h3c | (len >> 11), 0, 0);
      emit((len >> 3) & 'hff, 0, 0);
      emit(((len & 7) << 5) | 'h1f, 0, 0);
      emit('hfc, plen == 0, 0);
    endfunction

    function void parse_bit(bit b);
      int unsigned v;
      if (ph == PH_DONE || ph == PH_DROP) return;
      win = {win[30:0], b};
      if (fcnt > 1) begin
        fcnt--;
        return;
      end
      v = win;
      case (ph)
        PH_USE_SAME: begin
          if (v != 0) begin
            if (!cfg_ok || len_type != 0) go(PH_DROP, 1);
            else go(PH_LEN, 8);
          end else go(PH_VERSION, 1);
        end
        PH_VERSION: begin
          ver_a = 0;
          if (v != 0) go(PH_VERSION_A, 1); else go(PH_SKIP7, 7);
        end
        PH_VERSION_A: begin
          ver_a = v[0];
          if (v != 0) go(PH_DROP, 1); else fail();
        end
        PH_SKIP7: go(PH_NPROG, 4);
        PH_NPROG: if (v != 0) fail(); else go(PH_NLAYER, 3);
        PH_NLAYER: if (v != 0) fail(); else go(PH_AOT, 5);
        PH_AOT: begin
          if (v == 31) go(PH_AOT_EXT, 6);
          else begin
            obj = v; go(PH_SRI, 4);
          end
        end
        PH_AOT_EXT: begin
          obj = esc_type(v); go(PH_SRI, 4);
        end
        PH_SRI: begin
          ri = v & 'hf;
          if (v == 15) go(PH_RATE24, 24);
          else begin
            core_rate = rate_tab[v & 15]; go(PH_CHAN, 4);
          end
        end
        PH_RATE24: begin
          core_rate = v & 'hffffff; go(PH_CHAN, 4);
        end
        PH_CHAN: begin
          chan_cfg = v & 'hf;
          if (!in_range(core_rate) || v == 0 || v > 7) fail();
          else begin
            eri = 0;
            if (obj == 5) go(PH_ESRI, 4);
            else if (obj == 26) go(PH_PEEK, 9);
            else after_core();
          end
        end
        PH_PEEK: begin
          if (!(((v >> 6) & 3) != 0 && (v & 'h3f) == 0)) go(PH_ESRI, 4);
          else after_core();
          for (int i = 8; i >= 0; i--) parse_bit(v[i]);
        end
        PH_ESRI: begin
          eri = (v & 'hf) + 1;
          if (v == 15) go(PH_ERATE24, 24);
          else if (!in_range(rate_tab[v & 15])) fail();
          else go(PH_AOT2, 5);
        end
        PH_ERATE24: if (!in_range(v & 'hffffff)) fail(); else go(PH_AOT2, 5);
        PH_AOT2: begin
          if (v == 31) go(PH_AOT2_EXT, 6);
          else begin
            obj = v; go(PH_FRAMELEN, 1);
          end
        end
        PH_AOT2_EXT: begin
          obj = esc_type(v); go(PH_FRAMELEN, 1);
        end
        PH_FRAMELEN: if (v != 0) fail(); else go(PH_DEPENDS, 1);
        PH_DEPENDS: if (v != 0) go(PH_SKIPDELAY, 14); else go(PH_EXTFLAG, 1);
        PH_SKIPDELAY: go(PH_EXTFLAG, 1);
        PH_EXTFLAG: if (v != 0) go(PH_SKIPEXT3, 1); else go(PH_FLT, 3);
        PH_SKIPEXT3: go(PH_FLT, 3);
        PH_FLT: begin
          len_type = v & 7;
          if (v == 0) go(PH_SKIPFLT, 8);
          else if (v == 1) go(PH_SKIPFLT, 9);
          else if (v >= 3 && v <= 5) go(PH_SKIPFLT, 6);
          else if (v >= 6) go(PH_SKIPFLT, 1);
          else go(PH_OTHER, 1);
        end
        PH_SKIPFLT: go(PH_OTHER, 1);
        PH_OTHER: if (v != 0) go(PH_OTHERCHUNK, 9); else go(PH_CRC, 1);
        PH_OTHERCHUNK: if (v[8]) go(PH_OTHERCHUNK, 9); else go(PH_CRC, 1);
        PH_CRC: if (v != 0) go(PH_SKIPCRC, 8); else commit();
        PH_SKIPCRC: commit();
        PH_LEN: begin
          plen += v & 'hff;
          if (plen > 'hffff) plen = 'hffff;
          if (v == 255) go(PH_LEN, 8);
          else if (plen > 8184) begin
            emit(0, 1, 1);
            go(PH_DROP, 1);
          end else begin
            emit_header();
            prem = plen;
            if (prem == 0) go(PH_DONE, 1); else go(PH_PAY, 8);
          end
        end
        PH_PAY: begin
          prem = (prem - 1) & 'hffff;
          emit(v & 'hff, prem == 0, 0);
          if (prem == 0) go(PH_DONE, 1); else go(PH_PAY, 8);
        end
        default: go(PH_DROP, 1);
      endcase
    endfunction

    function void note_request(logic [7:0] d, logic e);
      nemit = 0;
      for (int i = 7; i >= 0; i--) parse_bit(d[i]);
      if (e) begin
        if (ph == PH_PAY) emit(0, 1, 1);
        else if (ph >= PH_VERSION && ph <= PH_SKIPCRC) cfg_ok = 0;
        start_element();
      end
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
      errors++;
    endtask

    task check_result(adts_item_t got);
      adts_item_t w;
      results++;
      if (frame_q.size() == 0) begin
        report("unexpected byte", got.data, 0);
        return;
      end
      w = frame_q.pop_front();
      if (got.data !== w.data) report("out_byte", got.data, w.data);
      if (got.last !== w.last) report("out_last", got.last, w.last);
      if (got.bad !== w.bad) report("frame_bad", got.bad, w.bad);
      if (got.ri !== w.ri) report("rate_index_out", got.ri, w.ri);
      if (got.eri !== w.eri) report("ext_rate_index_out", got.eri, w.eri);
      if (got.cc !== w.cc) report("channel_count", got.cc, w.cc);
    endtask
  endclass

  logic clk, rst_n;
  latm_in_if  in_ch();
  latm_out_if out_ch();

  latm_to_adts_repacker_top DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  adts_scoreboard sb = new();
  bit   calm, hold_req;
  int   idle_cycles, bytes_sent, elements;
  bit   bits_q[$];
  logic [7:0] elem_q[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    adts_item_t got;
    idle_cycles++;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_request(in_ch.data_byte, in_ch.element_end);
      idle_cycles = 0;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data = out_ch.out_byte; got.last = out_ch.out_last; got.bad = out_ch.frame_bad;
      got.ri = out_ch.rate_index_out; got.eri = out_ch.ext_rate_index_out;
      got.cc = out_ch.channel_count;
      sb.check_result(got);
      idle_cycles = 0;
    end
    if (idle_cycles >= 6000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // sink side: random stalls, calm stretches, one long hold-off
  initial begin
    out_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end else begin
        out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
      end
    end
  end

  task put(int unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) bits_q.push_back(v[i]);
  endtask

  task put_slot(int unsigned n);
    int unsigned r;
    r = n;
    while (r >= 255) begin
      put(255, 8);
      r -= 255;
    end
    put(r, 8);
    if (n <= 8184)
      for (int i = 0; i < n; i++) put($urandom, 8);
  endtask

  task put_aot(int unsigned a);
    put(a, 5);
    if (a == 31) put($urandom, 6);
  endtask

  task put_rate_index(int unsigned idx);
    put(idx, 4);
    if (idx == 15) put($urandom_range(6000, 100000), 24);
  endtask

  function int unsigned pick_idx();
    return $urandom_range(99) < 85 ? $urandom_range(0, 12) : $urandom_range(0, 15);
  endfunction

  task put_config(int unsigned a, int unsigned idx, int unsigned ch, int unsigned flt);
    put(0, 1);
    if ($urandom_range(99) < 5) begin
      put(1, 1);
      put($urandom, 1);
    end else put(0, 1);
    put($urandom, 7);
    put($urandom_range(99) < 4 ? $urandom_range(15) : 0, 4);
    put($urandom_range(99) < 4 ? $urandom_range(7) : 0, 3);
    put_aot(a);
    put_rate_index(idx);
    put(ch, 4);
    if (a == 5) begin
      put_rate_index(pick_idx());
      put_aot($urandom_range(99) < 80 ? 2 : $urandom_range(31));
    end
    put($urandom_range(99) < 5, 1);
    if ($urandom_range(1)) begin
      put(1, 1);
      put($urandom, 14);
    end else put(0, 1);
    if ($urandom_range(1)) put(2, 2); else put(0, 1);
    put(flt, 3);
    if (flt == 0) put($urandom, 8); else put($urandom, 9);
    if ($urandom_range(99) < 20) begin
      put(1, 1);
      put($urandom_range(255), 9);
    end else put(0, 1);
    if ($urandom_range(1)) put(256 | $urandom_range(255), 9); else put(0, 1);
  endtask

  task send_element(int unsigned cut);
    elem_q = {};
    while (bits_q.size() % 8 != 0) bits_q.push_back($urandom_range(1));
    while (bits_q.size() > 0) begin
      logic [7:0] b;
      for (int i = 0; i < 8; i++) b = {b[6:0], bits_q.pop_front()};
      elem_q.push_back(b);
    end
    while (cut > 0 && elem_q.size() > 1) begin
      void'(elem_q.pop_back());
      cut--;
    end
    foreach (elem_q[i]) begin
      while (!calm && $urandom_range(99) < 38) begin
        in_ch.valid <= 0;
        @(posedge clk);
      end
      in_ch.valid <= 1;
      in_ch.data_byte <= elem_q[i];
      in_ch.element_end <= (i == elem_q.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      bytes_sent++;
    end
    elements++;
  endtask

  task random_element();
    int unsigned k, n, cut;
    k = $urandom_range(99);
    n = $urandom_range(0, 12);
    if ($urandom_range(99) < 3) n = 255 + $urandom_range(0, 6);
    else if ($urandom_range(99) < 2) n = 8185 + $urandom_range(0, 2000);
    cut = $urandom_range(99) < 10 ? $urandom_range(1, 4) : 0;
    if (k < 60) begin
      put_config($urandom_range(99) < 70 ? ($urandom_range(3) == 0 ? 5 : 2) :
                 $urandom_range(31), pick_idx(),
                 $urandom_range(99) < 90 ? $urandom_range(1, 7) : $urandom_range(15),
                 $urandom_range(99) < 85 ? 0 : $urandom_range(7));
      put_slot(n);
    end else if (k < 90) begin
      put(1, 1);
      put_slot(n);
    end else begin
      repeat ($urandom_range(1, 6)) put($urandom, 8);
    end
    send_element(cut);
  endtask

  initial begin
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.data_byte = 0;
    in_ch.element_end = 0;
    calm = 0;
    hold_req = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // slot with no config yet, then zero slot with escaped type, later a truncated payload
    put(1, 1); put_slot(2); send_element(0);
    put_config(31, 3, 7, 0); put_slot(0); send_element(0);
    put_config(5, 6, 2, 0); put_slot(1); send_element(0);
    put(1, 1); put_slot(9); send_element(2);
    put_config(26, 11, 1, 0); put_slot(3); send_element(0);
    put_config(2, 13, 2, 0); put_slot(1); send_element(0);
    put_config(2, 4, 2, 1); put_slot(1); send_element(0);
    hold_req = 1;
    while (bytes_sent < 410) begin
      calm = (bytes_sent >= 150 && bytes_sent < 220);
      random_element();
    end
    in_ch.valid <= 0;
    in_ch.element_end <= 0;
    calm = 0;
    while (sb.frame_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d elements in %0d bytes, checked %0d output bytes",
             elements, bytes_sent, sb.results);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
